@@ sv/dpc_pkg.sv @@
// Shared constants for the disc pair collision response unit.
// No dependencies; used by the top level by scoped names.
package dpc_pkg;

   localparam int COORD_WIDTH_DEF = 24;   // Q16.8 coordinate width
   localparam int RADIUS_W        = 16;   // Q8.8 radius
   localparam int MASS_W          = 16;   // Q8.8 mass
   localparam int REST_W          = 17;   // Q1.16 restitution, up to just below 2.0
   localparam int FRAC_SHIFT      = 16;   // Q.16 impulse factor scale

   localparam logic [REST_W-1:0] REST_RESET = 17'd65536;
   localparam logic [REST_W:0]   REST_ONE   = 18'd65536;

endpackage

@@ sv/dpc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Generic; no package dependency. Caller guarantees num < den * 2**QUO_W.
module dpc_div_pipe #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 17,
   parameter int QUO_W = 18
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             rem_nz
);

   localparam int XW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   // entry 0 is the input register, entry k+1 holds the result of step k
   logic [XW-1:0]    rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];

   logic [XW-1:0]    rem_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [XW-1:0] trial;
      for (int k = 0; k < QUO_W; k++) begin
         trial     = XW'(den_ff[k]) << (QUO_W - 1 - k);
         quo_in[k] = quo_ff[k];
         if (rem_ff[k] >= trial) begin
            rem_in[k]                  = rem_ff[k] - trial;
            quo_in[k][QUO_W - 1 - k]   = 1'b1;
         end else begin
            rem_in[k] = rem_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= XW'(num);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k+1] <= rem_in[k];
            den_ff[k+1] <= den_ff[k];
            quo_ff[k+1] <= quo_in[k];
         end
      end
   end

   assign quo    = quo_ff[QUO_W];
   assign rem_nz = (rem_ff[QUO_W] != '0);

endmodule

@@ sv/disc_pair_collision_response_unit.sv @@
// Two-disc contact impulse, fully pipelined, one pair per clock unless stalled.
// Depends on dpc_pkg (constants) and dpc_div_pipe (pipelined divider).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  req_    | in        | req_valid/req_stall  | two discs: pos, vel, radius, mass
//  rsp_    | out       | rsp_valid/rsp_stall  | four velocities, collided, bad_mass
//  csr_    | in        | csr_valid/csr_ready  | restitution, Q1.16 (17 bits)
//
// One pair is taken per cycle unless stalled. A pair passes the front stages,
// the dividers, which retire one quotient bit per stage, then M1, M2 and output.
// Reset (synchronous) clears all valid bits and sets restitution to 1.0.
// A result that waits under rsp_stall freezes the whole pipe; req_stall rises
// in the same cycle, so nothing is dropped or repeated.
module disc_pair_collision_response_unit #(
   parameter int COORD_WIDTH = dpc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input pairs
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x_a,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y_a,
   input  logic signed [COORD_WIDTH-1:0]       req_vel_x_a,
   input  logic signed [COORD_WIDTH-1:0]       req_vel_y_a,
   input  logic [dpc_pkg::RADIUS_W-1:0]        req_radius_a,
   input  logic [dpc_pkg::MASS_W-1:0]          req_mass_a,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x_b,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y_b,
   input  logic signed [COORD_WIDTH-1:0]       req_vel_x_b,
   input  logic signed [COORD_WIDTH-1:0]       req_vel_y_b,
   input  logic [dpc_pkg::RADIUS_W-1:0]        req_radius_b,
   input  logic [dpc_pkg::MASS_W-1:0]          req_mass_b,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [COORD_WIDTH-1:0]       rsp_new_vel_x_a,
   output logic signed [COORD_WIDTH-1:0]       rsp_new_vel_y_a,
   output logic signed [COORD_WIDTH-1:0]       rsp_new_vel_x_b,
   output logic signed [COORD_WIDTH-1:0]       rsp_new_vel_y_b,
   output logic                                rsp_collided,
   output logic                                rsp_bad_mass,
   // restitution register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dpc_pkg::REST_W-1:0]          csr_data
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;                    // coordinate differences
   localparam int RSW   = dpc_pkg::RADIUS_W + 1;    // radius sum
   localparam int AXW   = RSW;                      // |offset| on the contact path
   localparam int SQW   = 2 * AXW;
   localparam int D2W   = SQW + 1;                  // squared distance
   localparam int RS2W  = 2 * RSW;
   localparam int DXS   = AXW + 1;                  // signed offset on contact path
   localparam int PRW   = DW + DXS;
   localparam int DOTW  = PRW + 1;
   localparam int PW    = DOTW;                     // approach product p
   localparam int PLW   = PW / 2;
   localparam int PHW   = PW - PLW;
   localparam int LPW   = PLW + AXW;
   localparam int HPW   = PHW + AXW;
   localparam int NUMW  = PW + AXW;                 // p * |c|
   localparam int QW    = W + 1;                    // mag <= |dv| < 2**(W+1)
   localparam int FW    = dpc_pkg::REST_W + 1;      // 1 + e, Q.16
   localparam int SW    = dpc_pkg::MASS_W + 1;      // mass sum
   localparam int FMW   = FW + dpc_pkg::MASS_W;
   localparam int DQW   = (QW > FW) ? QW : FW;
   localparam int DLAT  = DQW + 1;
   localparam int MPW   = FW + QW;
   localparam int DEW   = MPW - dpc_pkg::FRAC_SHIFT;
   localparam int SUMW  = DEW + 2;
   localparam int VELW  = 4 * W;
   localparam int SDW   = VELW + 4;
   // side vector layout
   localparam int SD_SX  = 3;
   localparam int SD_SY  = 2;
   localparam int SD_HIT = 1;
   localparam int SD_BAD = 0;

   // ---------------------------------------------------------------- control
   logic                   rsp_valid_ff, col_ff, badm_ff;
   logic adv;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   logic [dpc_pkg::REST_W-1:0] restitution_ff;
   logic [FW-1:0]              f_w;
   assign f_w = dpc_pkg::REST_ONE + FW'(restitution_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= dpc_pkg::REST_RESET;
      end else if (csr_valid && csr_ready) begin
         restitution_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // differences, radius sum, mass sum, numerator of the impulse factor, zero-mass flag
   logic                   v1_ff;
   logic signed [DW-1:0]   dx1_ff, dy1_ff, dvx1_ff, dvy1_ff;
   logic [RSW-1:0]         rs1_ff;
   logic [SW-1:0]          sm1_ff;
   logic [FMW-1:0]         fm1_ff;
   logic                   bad1_ff;
   logic [VELW-1:0]        vel1_ff;

   // ---------------------------------------------------------------- stage 2
   logic                   v2_ff, near2_ff, sx2_ff, sy2_ff, bad2_ff;
   logic [AXW-1:0]         ax2_ff, ay2_ff;
   logic [SQW-1:0]         sqx2_ff, sqy2_ff;
   logic [RS2W-1:0]        rr2_ff;
   logic signed [PRW-1:0]  prx2_ff, pry2_ff;
   logic [SW-1:0]          sm2_ff;
   logic [FMW-1:0]         fm2_ff;
   logic [VELW-1:0]        vel2_ff;

   logic [DW-1:0]          axf, ayf;
   logic signed [DXS-1:0]  dx18, dy18;
   assign axf  = dx1_ff[DW-1] ? $unsigned(-dx1_ff) : $unsigned(dx1_ff);
   assign ayf  = dy1_ff[DW-1] ? $unsigned(-dy1_ff) : $unsigned(dy1_ff);
   assign dx18 = dx1_ff[DXS-1:0];
   assign dy18 = dy1_ff[DXS-1:0];

   // ---------------------------------------------------------------- stage 3
   logic                   v3_ff, ok3_ff, sx3_ff, sy3_ff, bad3_ff;
   logic [D2W-1:0]         d2_3_ff;
   logic signed [DOTW-1:0] dot3_ff;
   logic [AXW-1:0]         ax3_ff, ay3_ff;
   logic [RS2W-1:0]        rr3_ff;
   logic [SW-1:0]          sm3_ff;
   logic [FMW-1:0]         fm3_ff;
   logic [VELW-1:0]        vel3_ff;

   // ---------------------------------------------------------------- stage 4
   logic                   v4_ff;
   logic [D2W-1:0]         d2_4_ff;
   logic [PW-1:0]          p4_ff;
   logic [AXW-1:0]         ax4_ff, ay4_ff;
   logic [SDW-1:0]         sd4_ff;
   logic [SW-1:0]          sm4_ff;
   logic [FMW-1:0]         fm4_ff;

   logic                   hit3;
   assign hit3 = ok3_ff && (d2_3_ff != '0) && (d2_3_ff <= D2W'(rr3_ff))
                 && (dot3_ff[DOTW-1] || (dot3_ff == '0));

   // ---------------------------------------------------------------- stage 5
   logic                   v5_ff;
   logic [D2W-1:0]         d2_5_ff;
   logic [LPW-1:0]         plx5_ff, ply5_ff;
   logic [HPW-1:0]         phx5_ff, phy5_ff;
   logic [SDW-1:0]         sd5_ff;
   logic [SW-1:0]          sm5_ff;
   logic [FMW-1:0]         fm5_ff;

   // ---------------------------------------------------------------- stage 6
   logic                   v6_ff;
   logic [D2W-1:0]         d2_6_ff;
   logic [NUMW-1:0]        nx6_ff, ny6_ff;
   logic [SDW-1:0]         sd6_ff;
   logic [SW-1:0]          sm6_ff;
   logic [FMW-1:0]         fm6_ff;

   // ---------------------------------------------------------------- dividers
   logic                   vd_ff  [DLAT];
   logic [SDW-1:0]         sdd_ff [DLAT];
   logic [DQW-1:0]         qx, qy, qt;
   logic                   tnz;

   dpc_div_pipe #(.NUM_W(NUMW), .DEN_W(D2W), .QUO_W(DQW)) u_div_x (
      .clock(clock), .enable(adv), .num(nx6_ff), .den(d2_6_ff), .quo(qx), .rem_nz()
   );
   dpc_div_pipe #(.NUM_W(NUMW), .DEN_W(D2W), .QUO_W(DQW)) u_div_y (
      .clock(clock), .enable(adv), .num(ny6_ff), .den(d2_6_ff), .quo(qy), .rem_nz()
   );
   // t_a = floor((1+e) m_b / (m_a+m_b)); t_b follows from the remainder
   dpc_div_pipe #(.NUM_W(FMW), .DEN_W(SW), .QUO_W(DQW)) u_div_t (
      .clock(clock), .enable(adv), .num(fm6_ff), .den(sm6_ff), .quo(qt), .rem_nz(tnz)
   );

   // ---------------------------------------------------------------- M1, M2
   logic                   vm1_ff, vm2_ff;
   logic [FW-1:0]          ta1_ff, tb1_ff;
   logic [QW-1:0]          mx1_ff, my1_ff;
   logic [SDW-1:0]         sdm1_ff, sdm2_ff;
   logic [MPW-1:0]         pax2_ff, pay2_ff, pbx2_ff, pby2_ff;

   // ---------------------------------------------------------------- output
   logic [W-1:0]           nvxa_ff, nvya_ff, nvxb_ff, nvyb_ff;

   function automatic logic [W-1:0] sat_w(input logic signed [SUMW-1:0] v);
      logic [SUMW-W:0] hi_bits;
      hi_bits = v[SUMW-1:W-1];
      if (hi_bits == '0 || hi_bits == '1) begin
         return v[W-1:0];
      end else if (v[SUMW-1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   logic signed [SUMW-1:0] vxa_s, vya_s, vxb_s, vyb_s;
   logic signed [SUMW-1:0] dax_s, day_s, dbx_s, dby_s;
   logic signed [SUMW-1:0] nxa_s, nya_s, nxb_s, nyb_s;

   always_comb begin
      vxa_s = SUMW'($signed(sdm2_ff[4+4*W-1 -: W]));
      vya_s = SUMW'($signed(sdm2_ff[4+3*W-1 -: W]));
      vxb_s = SUMW'($signed(sdm2_ff[4+2*W-1 -: W]));
      vyb_s = SUMW'($signed(sdm2_ff[4+W-1 -: W]));
      dax_s = $signed({2'b00, pax2_ff[MPW-1:dpc_pkg::FRAC_SHIFT]});
      day_s = $signed({2'b00, pay2_ff[MPW-1:dpc_pkg::FRAC_SHIFT]});
      dbx_s = $signed({2'b00, pbx2_ff[MPW-1:dpc_pkg::FRAC_SHIFT]});
      dby_s = $signed({2'b00, pby2_ff[MPW-1:dpc_pkg::FRAC_SHIFT]});
      // a moves along +d, b along -d; a zero offset gives a zero delta
      nxa_s = sdm2_ff[SD_SX] ? vxa_s - dax_s : vxa_s + dax_s;
      nya_s = sdm2_ff[SD_SY] ? vya_s - day_s : vya_s + day_s;
      nxb_s = sdm2_ff[SD_SX] ? vxb_s + dbx_s : vxb_s - dbx_s;
      nyb_s = sdm2_ff[SD_SY] ? vyb_s + dby_s : vyb_s - dby_s;
   end

   // ---------------------------------------------------------------- valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         for (int i = 0; i < DLAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
         vm1_ff       <= 1'b0;
         vm2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         vd_ff[0]     <= v6_ff;
         for (int i = 1; i < DLAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         vm1_ff       <= vd_ff[DLAT-1];
         vm2_ff       <= vm1_ff;
         rsp_valid_ff <= vm2_ff;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         dx1_ff  <= DW'(req_pos_x_a) - DW'(req_pos_x_b);
         dy1_ff  <= DW'(req_pos_y_a) - DW'(req_pos_y_b);
         dvx1_ff <= DW'(req_vel_x_a) - DW'(req_vel_x_b);
         dvy1_ff <= DW'(req_vel_y_a) - DW'(req_vel_y_b);
         rs1_ff  <= RSW'(req_radius_a) + RSW'(req_radius_b);
         sm1_ff  <= SW'(req_mass_a) + SW'(req_mass_b);
         fm1_ff  <= FMW'(f_w) * FMW'(req_mass_b);
         bad1_ff <= (req_mass_a == '0) || (req_mass_b == '0);
         vel1_ff <= {req_vel_x_a, req_vel_y_a, req_vel_x_b, req_vel_y_b};
         // stage 2: box test, squares, dot product terms
         near2_ff <= (axf <= DW'(rs1_ff)) && (ayf <= DW'(rs1_ff));
         ax2_ff   <= axf[AXW-1:0];
         ay2_ff   <= ayf[AXW-1:0];
         sqx2_ff  <= SQW'(axf[AXW-1:0]) * SQW'(axf[AXW-1:0]);
         sqy2_ff  <= SQW'(ayf[AXW-1:0]) * SQW'(ayf[AXW-1:0]);
         rr2_ff   <= RS2W'(rs1_ff) * RS2W'(rs1_ff);
         prx2_ff  <= PRW'(dvx1_ff) * PRW'(dx18);
         pry2_ff  <= PRW'(dvy1_ff) * PRW'(dy18);
         sx2_ff   <= dx1_ff[DW-1];
         sy2_ff   <= dy1_ff[DW-1];
         bad2_ff  <= bad1_ff;
         sm2_ff   <= sm1_ff;
         fm2_ff   <= fm1_ff;
         vel2_ff  <= vel1_ff;
         // stage 3: distance squared, dot product
         ok3_ff  <= near2_ff && !bad2_ff;
         d2_3_ff <= D2W'(sqx2_ff) + D2W'(sqy2_ff);
         dot3_ff <= DOTW'(prx2_ff) + DOTW'(pry2_ff);
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         rr3_ff  <= rr2_ff;
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         bad3_ff <= bad2_ff;
         sm3_ff  <= sm2_ff;
         fm3_ff  <= fm2_ff;
         vel3_ff <= vel2_ff;
         // stage 4: contact decision, approach product
         d2_4_ff <= d2_3_ff;
         p4_ff   <= PW'(-dot3_ff);
         ax4_ff  <= ax3_ff;
         ay4_ff  <= ay3_ff;
         sd4_ff  <= {vel3_ff, sx3_ff, sy3_ff, hit3, bad3_ff};
         sm4_ff  <= sm3_ff;
         fm4_ff  <= fm3_ff;
         // stage 5: p * |c| as two partial products
         d2_5_ff <= d2_4_ff;
         plx5_ff <= LPW'(p4_ff[PLW-1:0]) * LPW'(ax4_ff);
         phx5_ff <= HPW'(p4_ff[PW-1:PLW]) * HPW'(ax4_ff);
         ply5_ff <= LPW'(p4_ff[PLW-1:0]) * LPW'(ay4_ff);
         phy5_ff <= HPW'(p4_ff[PW-1:PLW]) * HPW'(ay4_ff);
         sd5_ff  <= sd4_ff;
         sm5_ff  <= sm4_ff;
         fm5_ff  <= fm4_ff;
         // stage 6: combine partials
         d2_6_ff <= d2_5_ff;
         nx6_ff  <= (NUMW'(phx5_ff) << PLW) + NUMW'(plx5_ff);
         ny6_ff  <= (NUMW'(phy5_ff) << PLW) + NUMW'(ply5_ff);
         sd6_ff  <= sd5_ff;
         sm6_ff  <= sm5_ff;
         fm6_ff  <= fm5_ff;
         // side data alongside the dividers
         sdd_ff[0] <= sd6_ff;
         for (int i = 1; i < DLAT; i++) begin
            sdd_ff[i] <= sdd_ff[i-1];
         end
         // M1: t_a + t_b is 1+e, less one when the division was inexact
         ta1_ff  <= qt[FW-1:0];
         tb1_ff  <= f_w - qt[FW-1:0] - FW'(tnz);
         mx1_ff  <= qx[QW-1:0];
         my1_ff  <= qy[QW-1:0];
         sdm1_ff <= sdd_ff[DLAT-1];
         // M2: velocity deltas, Q.16 scaled
         pax2_ff <= MPW'(ta1_ff) * MPW'(mx1_ff);
         pay2_ff <= MPW'(ta1_ff) * MPW'(my1_ff);
         pbx2_ff <= MPW'(tb1_ff) * MPW'(mx1_ff);
         pby2_ff <= MPW'(tb1_ff) * MPW'(my1_ff);
         sdm2_ff <= sdm1_ff;
         // output register
         col_ff  <= sdm2_ff[SD_HIT];
         badm_ff <= sdm2_ff[SD_BAD];
         if (sdm2_ff[SD_HIT]) begin
            nvxa_ff <= sat_w(nxa_s);
            nvya_ff <= sat_w(nya_s);
            nvxb_ff <= sat_w(nxb_s);
            nvyb_ff <= sat_w(nyb_s);
         end else begin
            nvxa_ff <= sdm2_ff[4+4*W-1 -: W];
            nvya_ff <= sdm2_ff[4+3*W-1 -: W];
            nvxb_ff <= sdm2_ff[4+2*W-1 -: W];
            nvyb_ff <= sdm2_ff[4+W-1 -: W];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_vel_x_a = nvxa_ff;
   assign rsp_new_vel_y_a = nvya_ff;
   assign rsp_new_vel_x_b = nvxb_ff;
   assign rsp_new_vel_y_b = nvyb_ff;
   assign rsp_collided    = col_ff;
   assign rsp_bad_mass    = badm_ff;

   // ---------------------------------------------------------------- checks
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_last_stage_lands : assert property (@(posedge clock) disable iff (reset)
      adv && vm2_ff |=> rsp_valid)
      else $error("item in last stage did not reach the output register");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_mass |-> !rsp_collided)
      else $error("impulse applied despite zero mass");

   a_frozen_pipe : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sd6_ff) && $stable(v6_ff))
      else $error("pipeline moved while output held");

endmodule
